// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and defaults for the latency sample statistics core.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int LSS_WARMUP    = 4;
    localparam int LSS_CAPACITY  = 64;
    localparam int LSS_CHUNK_MAX = 16;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] generation_tag;
        logic        token_collect;
        logic [31:0] latency_us;
        logic        success;
        logic [7:0]  read_offset;
        logic [7:0]  read_capacity;
        logic        tmr_ready;
        logic        tmr_advanced;
        logic [31:0] core_hz;
    } lss_cmd_t;

    typedef struct packed {
        logic [31:0] current_generation;
        logic        collecting;
        logic        sample_valid;
        logic [31:0] sample_value;
        logic        last_of_run;
        logic [31:0] min_latency;
        logic [31:0] max_latency;
        logic [63:0] total_latency;
        logic [6:0]  stored_count;
        logic [31:0] failures;
        logic        run_complete;
        logic        run_valid;
    } lss_res_t;

endpackage

// ===== rtl/latency_sample_statistics_core.sv =====
// ----------------------------------------------------------------------------
// latency_sample_statistics_core
// Latency statistics with a sample store and chunked sample readout.
// ----------------------------------------------------------------------------
// Usage: record (op 0), clear (op 1) and the unused op 3 each produce one
// status transaction and pass through accept, update and result steps. A
// read (op 2) that passes its checks is accepted, has its request checked,
// and then takes a synchronous store read and a load of the result register
// for each of its n samples (n at most CHUNK_MAX). A rejected read behaves
// like a status op. Result stalls hold the block until the output register
// is free. The command side stalls while an item is in flight; one
// finished result may wait in the output register while the next command
// is accepted. The store has one write port, one registered read port and
// no reset: only entries below the current fill count are ever read, and
// reads and writes never overlap because items are processed one at a time.
// ----------------------------------------------------------------------------
module latency_sample_statistics_core #(
    parameter int WARMUP    = lss_pkg::LSS_WARMUP,
    parameter int CAPACITY  = lss_pkg::LSS_CAPACITY,
    parameter int CHUNK_MAX = lss_pkg::LSS_CHUNK_MAX
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  lss_pkg::lss_cmd_t cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output lss_pkg::lss_res_t res
);
    import lss_pkg::*;

    // Widths derived from the configuration
    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SCW = $clog2(CAPACITY + 1);
    localparam int WW  = (WARMUP > 0) ? $clog2(WARMUP + 1) : 1;
    localparam int CW  = $clog2(CHUNK_MAX + 1);
    localparam int DW  = (SCW > 8) ? SCW : 8;

    localparam logic [SCW-1:0] CAP_SC    = SCW'(CAPACITY);
    localparam logic [WW-1:0]  WARMUP_W  = WW'(WARMUP);
    localparam logic [DW-1:0]  CHUNK_D   = DW'(CHUNK_MAX);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_RESP = 5'b00100,
        ST_RD   = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    lss_cmd_t        in_reg;

    // Statistics registers
    logic [31:0]     generation_reg, generation_next;
    logic [31:0]     fail_reg, fail_next;
    logic [31:0]     stale_reg, stale_next;
    logic [WW-1:0]   warm_reg, warm_next;
    logic [SCW-1:0]  count_reg, count_next;
    logic [31:0]     min_reg, min_next;
    logic [31:0]     max_reg, max_next;
    logic [63:0]     total_reg, total_next;
    logic            done_reg, done_next;

    // Readout control
    logic [AW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    // Sample store
    logic [31:0]     store_mem [CAPACITY];
    logic [31:0]     rd_data_reg;
    logic            wr_en;

    // Output register
    lss_res_t        res_reg, res_next;
    logic            res_valid_reg;
    logic            out_free;
    logic            load_out;

    // Read request checks and chunk length
    logic [DW-1:0]   avail;
    logic [DW-1:0]   len_cap;
    logic [DW-1:0]   len_chunk;
    logic            read_ok;
    logic            complete;

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign avail     = DW'(count_reg) - DW'(in_reg.read_offset);
    assign len_cap   = (avail > DW'(in_reg.read_capacity)) ? DW'(in_reg.read_capacity) : avail;
    assign len_chunk = (len_cap > CHUNK_D) ? CHUNK_D : len_cap;
    assign read_ok   = (in_reg.generation_tag == generation_reg)
                    && (DW'(in_reg.read_offset) < DW'(count_reg))
                    && (in_reg.read_capacity != 8'd0);

    assign complete  = done_reg && (warm_reg == WARMUP_W) && (count_reg == CAP_SC);

    // Sequencer and statistics update
    always_comb
    begin
        state_next      = state_reg;
        generation_next = generation_reg;
        fail_next       = fail_reg;
        stale_next      = stale_reg;
        warm_next       = warm_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        wr_en           = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
                unique case (op_t'(in_reg.op))
                    OP_RECORD:
                    begin
                        if (in_reg.token_collect && !done_reg)
                        begin
                            if (in_reg.generation_tag != generation_reg)
                            begin
                                stale_next = stale_reg + 32'd1;
                            end
                            else
                            begin
                                if (!in_reg.success)
                                begin
                                    fail_next = fail_reg + 32'd1;
                                end
                                if (warm_reg < WARMUP_W)
                                begin
                                    warm_next = warm_reg + WW'(1);
                                end
                                else if (in_reg.success)
                                begin
                                    if (count_reg >= CAP_SC)
                                    begin
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_en = 1'b1;
                                        if (count_reg == '0 || in_reg.latency_us < min_reg)
                                        begin
                                            min_next = in_reg.latency_us;
                                        end
                                        if (in_reg.latency_us > max_reg)
                                        begin
                                            max_next = in_reg.latency_us;
                                        end
                                        total_next = total_reg + {32'd0, in_reg.latency_us};
                                        count_next = count_reg + SCW'(1);
                                        if (count_reg + SCW'(1) == CAP_SC)
                                        begin
                                            done_next = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        generation_next = generation_reg + 32'd1;
                        fail_next       = '0;
                        stale_next      = '0;
                        warm_next       = '0;
                        count_next      = '0;
                        min_next        = '0;
                        max_next        = '0;
                        total_next      = '0;
                        done_next       = 1'b0;
                    end
                    OP_READ:
                    begin
                        if (read_ok)
                        begin
                            idx_next   = AW'(in_reg.read_offset);
                            cnt_next   = CW'(len_chunk);
                            state_next = ST_RD;
                        end
                    end
                    OP_NONE:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                // store read issued this cycle, data lands in rd_data_reg
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ST_RD;
                    end
                end
            end
        endcase
    end

    // Result assembly: status snapshot plus sample for readout
    always_comb
    begin
        res_next.current_generation = generation_reg;
        res_next.collecting         = !done_reg;
        res_next.sample_valid       = (state_reg == ST_EMIT);
        res_next.sample_value       = (state_reg == ST_EMIT) ? rd_data_reg : 32'd0;
        res_next.last_of_run        = (state_reg != ST_EMIT) || (cnt_reg == CW'(1));
        res_next.min_latency        = min_reg;
        res_next.max_latency        = max_reg;
        res_next.total_latency      = total_reg;
        res_next.stored_count       = 7'(count_reg);
        res_next.failures           = fail_reg;
        res_next.run_complete       = complete;
        res_next.run_valid          = complete && in_reg.tmr_ready
                                   && in_reg.tmr_advanced
                                   && (in_reg.core_hz != 32'd0)
                                   && (fail_reg == 32'd0) && (stale_reg == 32'd0);
    end

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            generation_reg <= '0;
            fail_reg       <= '0;
            stale_reg      <= '0;
            warm_reg       <= '0;
            count_reg      <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            generation_reg <= generation_next;
            fail_reg       <= fail_next;
            stale_reg      <= stale_next;
            warm_reg       <= warm_next;
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            if (load_out)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            in_reg <= cmd;
        end
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[AW'(count_reg)] <= in_reg.latency_us;
        end
        rd_data_reg <= store_mem[idx_reg];
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_SC)
        else $error("fill count beyond capacity");

    a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !(state_reg == ST_EXEC)) |-> (count_reg == CAP_SC))
        else $error("collection closed with store not full");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_EMIT) |->
            (cnt_reg != '0) && (SCW'(idx_reg) < count_reg))
        else $error("readout beyond stored samples");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(res_valid_reg && res_stall))
        else $error("result register overwritten while held");
`endif

endmodule
